/* rtl/core/aewd_pkg.sv */
// aewd_pkg: shared types and constants of the adc event word decoder
// used by aewd_ctrl, aewd_dp and adc_event_word_decoder; no dependencies
package aewd_pkg;

	localparam int HIT_DEPTH = 32;
	localparam int HIT_CW = $clog2(HIT_DEPTH + 1);
	localparam int HIT_AW = (HIT_DEPTH > 1) ? $clog2(HIT_DEPTH) : 1;
	localparam int ENTRY_W = 20;

	// word types in bits 31..30
	localparam logic [1:0] WT_DATA   = 2'b00;
	localparam logic [1:0] WT_HEADER = 2'b01;
	localparam logic [1:0] WT_EOE    = 2'b11;

	localparam logic [7:0]  HDR_MARK  = 8'h40;
	localparam logic [9:0]  HIT_MARK  = 10'd16;
	localparam logic [15:0] LOW_MARK  = 16'd1152;
	localparam logic [15:0] AMP_OVER  = 16'hFFFF;

	// configuration register indexes
	localparam logic CFG_MODE   = 1'b0;
	localparam logic CFG_MODULE = 1'b1;

	typedef enum logic [1:0] {
		KIND_HIT      = 2'd0,
		KIND_BAD_HDR  = 2'd1,
		KIND_BAD_DATA = 2'd2,
		KIND_DROP     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DRAIN_RD,
		ST_DRAIN_OUT
	} state_t;

	typedef struct packed {
		logic load_word;
		logic commit;
		logic drain_rd;
		logic drain_out;
		logic drain_done;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic needs_out;
		logic drain;
		logic drain_last;
	} status_t;

endpackage

/* rtl/core/adc_event_word_decoder.sv */
// adc_event_word_decoder: top level of the adc readout word decoder
// an accepted word is registered in word_q and decoded; its result enters the output register once it is free
// a new word is taken only in the idle state, after the previous word is done; an
// extended-mode end-of-event word drains its N buffered hits through the registered hit store read port
// reset: arst_n clears config, event counter, hit count, timestamp and handshakes
// the hit store itself is not cleared; only entries below the hit count are read
module adc_event_word_decoder import aewd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	output logic        word_stall,
	input  logic [31:0] data_word,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  module_id,
	output logic [4:0]  channel,
	output logic [15:0] amplitude,
	output logic        out_of_range,
	output logic [63:0] stamp,
	output logic        stamp_valid,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	aewd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.status     (status),
		.cmd        (cmd)
	);

	aewd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_word    (data_word),
		.cmd          (cmd),
		.status       (status),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_kind  (result_kind),
		.module_id    (module_id),
		.channel      (channel),
		.amplitude    (amplitude),
		.out_of_range (out_of_range),
		.stamp        (stamp),
		.stamp_valid  (stamp_valid),
		.last         (last)
	);

endmodule

/* rtl/core/aewd_ctrl.sv */
// aewd_ctrl: sequencing state machine of the adc event word decoder
// depends on aewd_pkg; drives aewd_dp through cmd_t, reads status_t
module aewd_ctrl import aewd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    word_valid,
	output logic    word_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (word_valid) begin
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.drain) begin
					state_nxt = ST_DRAIN_RD;
				end else if (!status.needs_out || status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DRAIN_RD: begin
				state_nxt = ST_DRAIN_OUT;
			end
			ST_DRAIN_OUT: begin
				if (status.out_free) begin
					state_nxt = status.drain_last ? ST_IDLE : ST_DRAIN_RD;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		word_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				word_stall = 1'b0;
				cmd.load_word = word_valid;
			end
			ST_DECODE: begin
				cmd.commit = !status.drain && (!status.needs_out || status.out_free);
			end
			ST_DRAIN_RD: begin
				cmd.drain_rd = 1'b1;
			end
			ST_DRAIN_OUT: begin
				cmd.drain_out = status.out_free;
				cmd.drain_done = status.out_free && status.drain_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* rtl/core/aewd_dp.sv */
// aewd_dp: word decode, hit store, event state and output register
// depends on aewd_pkg; commanded by aewd_ctrl
module aewd_dp import aewd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] data_word,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic        cfg_valid,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [7:0]  module_id,
	output logic [4:0]  channel,
	output logic [15:0] amplitude,
	output logic        out_of_range,
	output logic [63:0] stamp,
	output logic        stamp_valid,
	output logic        last
);

	logic               mode_q;
	logic [7:0]         module_q;
	logic [63:0]        event_counter_q;
	logic [HIT_CW-1:0]  hit_count_q;
	logic [15:0]        stamp_low_q;
	logic               stamp_low_seen_q;
	logic [31:0]        word_q;
	logic [HIT_AW-1:0]  rd_idx_q;
	logic [ENTRY_W-1:0] rdata_s1;
	logic [ENTRY_W-1:0] hit_mem [HIT_DEPTH];

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  module_id_q;
	logic [4:0]  channel_q;
	logic [15:0] amplitude_q;
	logic        oor_q;
	logic [63:0] stamp_q;
	logic        stamp_valid_q;
	logic        last_q;

	logic        is_hdr;
	logic        is_data;
	logic        is_eoe;
	logic        is_hit;
	logic        is_low;
	logic        store_full;
	logic        hit_store_wr;
	logic        out_free;
	kind_t       dec_kind;
	logic        dec_out;
	logic [15:0] dec_amp;
	logic [15:0] rd_amp;
	logic [63:0] ext_stamp;

	// register requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			module_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:   mode_q <= cfg_data[0];
				CFG_MODULE: module_q <= cfg_data;
				default:    mode_q <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			word_q <= data_word;
		end
	end

	// word decode
	always_comb begin
		is_hdr = (word_q[31:30] == WT_HEADER);
		is_data = (word_q[31:30] == WT_DATA);
		is_eoe = (word_q[31:30] == WT_EOE);
		is_hit = is_data && (word_q[31:22] == HIT_MARK);
		is_low = is_data && mode_q && (word_q[31:16] == LOW_MARK);
		store_full = (hit_count_q >= HIT_CW'(HIT_DEPTH));
		dec_amp = word_q[14] ? AMP_OVER : {2'b00, word_q[13:0]};
		dec_kind = KIND_HIT;
		dec_out = 1'b0;
		if (is_hdr) begin
			dec_kind = KIND_BAD_HDR;
			dec_out = (word_q[31:24] != HDR_MARK);
		end else if (is_hit) begin
			dec_kind = mode_q ? KIND_DROP : KIND_HIT;
			dec_out = !mode_q || store_full;
		end else if (is_data && !is_low && (word_q != 32'd0)) begin
			dec_kind = KIND_BAD_DATA;
			dec_out = 1'b1;
		end
		hit_store_wr = cmd.commit && is_hit && mode_q && !store_full;
	end

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		status.out_free = out_free;
		status.needs_out = dec_out;
		status.drain = is_eoe && mode_q && (hit_count_q != '0);
		status.drain_last = ({1'b0, rd_idx_q} == HIT_CW'(hit_count_q - 1'b1));
	end

	// hit store
	always_ff @(posedge clk) begin
		if (hit_store_wr) begin
			hit_mem[hit_count_q[HIT_AW-1:0]] <= {word_q[20:16], word_q[14:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain_rd) begin
			rdata_s1 <= hit_mem[rd_idx_q];
		end
	end

	// event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_counter_q <= '0;
			hit_count_q <= '0;
			stamp_low_q <= '0;
			stamp_low_seen_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			if (cmd.load_word) begin
				rd_idx_q <= '0;
			end else if (cmd.drain_out) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.commit) begin
				if (is_hdr || is_eoe) begin
					hit_count_q <= '0;
					stamp_low_q <= '0;
					stamp_low_seen_q <= 1'b0;
				end else if (is_low) begin
					stamp_low_q <= word_q[15:0];
					stamp_low_seen_q <= 1'b1;
				end else if (hit_store_wr) begin
					hit_count_q <= hit_count_q + 1'b1;
				end
				if (is_eoe && !mode_q) begin
					event_counter_q <= event_counter_q + 64'd1;
				end
			end else if (cmd.drain_done) begin
				hit_count_q <= '0;
				stamp_low_q <= '0;
				stamp_low_seen_q <= 1'b0;
			end
		end
	end

	// output register
	assign ext_stamp = stamp_low_seen_q ? {18'd0, word_q[29:0], stamp_low_q} : '1;
	assign rd_amp = rdata_s1[14] ? AMP_OVER : {2'b00, rdata_s1[13:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.commit && dec_out) || cmd.drain_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && dec_out) begin
			kind_q <= dec_kind;
			module_id_q <= module_q;
			last_q <= 1'b1;
			if (dec_kind == KIND_HIT || dec_kind == KIND_DROP) begin
				channel_q <= word_q[20:16];
				amplitude_q <= dec_amp;
				oor_q <= word_q[14];
			end else begin
				channel_q <= '0;
				amplitude_q <= '0;
				oor_q <= 1'b0;
			end
			stamp_q <= (dec_kind == KIND_HIT) ? event_counter_q : '0;
			stamp_valid_q <= (dec_kind == KIND_HIT);
		end else if (cmd.drain_out) begin
			kind_q <= KIND_HIT;
			module_id_q <= module_q;
			last_q <= status.drain_last;
			channel_q <= rdata_s1[19:15];
			amplitude_q <= rd_amp;
			oor_q <= rdata_s1[14];
			stamp_q <= ext_stamp;
			stamp_valid_q <= stamp_low_seen_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_kind = kind_q;
	assign module_id = module_id_q;
	assign channel = channel_q;
	assign amplitude = amplitude_q;
	assign out_of_range = oor_q;
	assign stamp = stamp_q;
	assign stamp_valid = stamp_valid_q;
	assign last = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hit_count_q <= HIT_CW'(HIT_DEPTH))
		else $error("hit count above store depth");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.commit && dec_out) || cmd.drain_out) |-> out_free)
		else $error("output register loaded while a request is stalled");

	a_drain_ext: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_rd |-> (mode_q && is_eoe && hit_count_q != '0))
		else $error("store drain outside an extended end of event");

	a_drain_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain_done |=> (hit_count_q == '0 && !stamp_low_seen_q))
		else $error("store not emptied after drain");

endmodule

/* tb/sv/testbench.sv */
// testbench: self-checking bench for adc_event_word_decoder, predicting every
// result of a directed then randomized word stream and comparing field by field
// depends on aewd_pkg and the adc_event_word_decoder rtl
module testbench import aewd_pkg::*;;

	localparam logic [1:0] WT_UNUSED = 2'b10;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  mod;
		logic [4:0]  ch;
		logic [15:0] amp;
		logic        oor;
		logic [63:0] stamp;
		logic        sval;
		logic        last;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        word_valid = 1'b0;
	logic        word_stall;
	logic [31:0] data_word = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  module_id;
	logic [4:0]  channel;
	logic [15:0] amplitude;
	logic        out_of_range;
	logic [63:0] stamp;
	logic        stamp_valid;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [7:0]  cfg_data = '0;

	logic [31:0] word_queue[$];
	result_t     due_results[$];

	// predictor state
	logic        ext_mode = 1'b0;
	logic [7:0]  module_num = '0;
	logic [63:0] event_count = '0;
	logic [20:0] hit_store[HIT_DEPTH];
	int          held_hits = 0;
	logic [15:0] low_stamp = '0;
	logic        low_seen = 1'b0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int send_window = 0;
	int recv_window = 0;
	int errors = 0;
	int words_taken = 0;
	int results_checked = 0;
	int reg_writes = 0;

	adc_event_word_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(word_valid),
		.word_stall(word_stall),
		.data_word(data_word),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_kind(result_kind),
		.module_id(module_id),
		.channel(channel),
		.amplitude(amplitude),
		.out_of_range(out_of_range),
		.stamp(stamp),
		.stamp_valid(stamp_valid),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// positive window counts calm cycles, negative counts cycles that may idle
	function automatic bit idle_roll(input int pct, inout int window);
		if (window == 0) begin
			if ($urandom_range(0, 3) == 0)
				window = $urandom_range(5, 40);
			else
				window = -$urandom_range(5, 60);
		end
		if (window > 0) begin
			window--;
			return 1'b0;
		end
		window++;
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic result_t make_result(kind_t kind, logic [4:0] ch, logic [15:0] amp,
			logic oor, logic [63:0] st, logic sv);
		result_t r;
		r.kind = kind;
		r.mod = module_num;
		r.ch = ch;
		r.amp = amp;
		r.oor = oor;
		r.stamp = st;
		r.sval = sv;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void decode_word(input logic [31:0] w);
		result_t     outs[$];
		logic [15:0] amp;
		logic [63:0] st;
		logic        sv;
		logic [20:0] e;
		amp = w[14] ? AMP_OVER : {2'b00, w[13:0]};
		case (w[31:30])
			WT_HEADER: begin
				held_hits = 0;
				low_stamp = '0;
				low_seen = 1'b0;
				if (w[31:24] != HDR_MARK)
					outs.insert(outs.size(),
						make_result(KIND_BAD_HDR, '0, '0, 1'b0, '0, 1'b0));
			end
			WT_DATA: begin
				if (w[31:22] == HIT_MARK) begin
					if (!ext_mode)
						outs.insert(outs.size(), make_result(KIND_HIT, w[20:16], amp,
							w[14], event_count, 1'b1));
					else if (held_hits >= HIT_DEPTH)
						outs.insert(outs.size(), make_result(KIND_DROP, w[20:16], amp,
							w[14], '0, 1'b0));
					else begin
						hit_store[held_hits] = {w[20:16], w[14], w[13:0]};
						held_hits++;
					end
				end else if (w[31:16] == LOW_MARK && ext_mode) begin
					low_stamp = w[15:0];
					low_seen = 1'b1;
				end else if (w != 32'h0) begin
					outs.insert(outs.size(),
						make_result(KIND_BAD_DATA, '0, '0, 1'b0, '0, 1'b0));
				end
			end
			WT_EOE: begin
				if (!ext_mode) begin
					event_count++;
				end else begin
					st = low_seen ? {18'h0, w[29:0], low_stamp} : '1;
					sv = low_seen;
					for (int i = 0; i < held_hits; i++) begin
						e = hit_store[i];
						outs.insert(outs.size(), make_result(KIND_HIT, e[19:15],
							e[14] ? AMP_OVER : {2'b00, e[13:0]}, e[14], st, sv));
					end
				end
				held_hits = 0;
				low_stamp = '0;
				low_seen = 1'b0;
			end
			default: ;
		endcase
		if (outs.size() != 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i])
			due_results.insert(due_results.size(), outs[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid <= 1'b0;
		end else begin
			if (word_valid && !word_stall) begin
				decode_word(data_word);
				words_taken++;
			end
			if (word_valid && word_stall) begin
			end else if (word_queue.size() == 0 || idle_roll(send_idle_pct, send_window)) begin
				word_valid <= 1'b0;
			end else begin
				word_valid <= 1'b1;
				data_word <= word_queue.pop_front();
			end
		end
	end

	task automatic check_field(input string name, input logic [63:0] want, got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				$error("result with nothing outstanding: kind %0d channel %0d",
					result_kind, channel);
				errors++;
			end else begin
				want = due_results.pop_front();
				check_field("result_kind", want.kind, result_kind);
				check_field("module_id", want.mod, module_id);
				check_field("channel", want.ch, channel);
				check_field("amplitude", want.amp, amplitude);
				check_field("out_of_range", want.oor, out_of_range);
				check_field("stamp", want.stamp, stamp);
				check_field("stamp_valid", want.sval, stamp_valid);
				check_field("last", want.last, last);
				results_checked++;
			end
		end
		result_stall <= arst_n && idle_roll(recv_stall_pct, recv_window);
	end

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_MODE)
			ext_mode = val[0];
		else
			module_num = val;
		reg_writes++;
	endtask

	task automatic settle();
		while (word_queue.size() != 0 || word_valid || due_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	function automatic logic [31:0] hit_word(logic [4:0] ch, logic oor, logic [13:0] raw);
		return {HIT_MARK, 1'($urandom()), ch, 1'($urandom()), oor, raw};
	endfunction

	function automatic logic [31:0] random_hit();
		logic [13:0] raw;
		case ($urandom_range(0, 5))
			0: raw = '0;
			1: raw = '1;
			default: raw = 14'($urandom());
		endcase
		return hit_word(5'($urandom()), $urandom_range(0, 3) == 0, raw);
	endfunction

	function automatic logic [31:0] good_header();
		return {HDR_MARK, 24'($urandom())};
	endfunction

	function automatic logic [31:0] eoe_word();
		return {WT_EOE, 30'($urandom())};
	endfunction

	function automatic logic [31:0] noise_word();
		case ($urandom_range(0, 8))
			0: return {WT_HEADER, 6'($urandom_range(1, 63)), 24'($urandom())};
			1: return good_header();
			2: return {WT_DATA, 30'($urandom())};
			3: return 32'h0;
			4: return {WT_UNUSED, 30'($urandom())};
			5: return eoe_word();
			6: return random_hit();
			7: return {LOW_MARK, 16'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	// zero words and unused word types are not counted
	function automatic int add_word(input logic [31:0] w);
		word_queue.insert(word_queue.size(), w);
		return (w != 32'h0 && w[31:30] != WT_UNUSED) ? 1 : 0;
	endfunction

	task automatic queue_traffic(input int n);
		int sent;
		int k;
		bit first;
		sent = 0;
		first = 1'b1;
		while (sent < n) begin
			if ($urandom_range(0, 4) != 0) begin
				sent += add_word(good_header());
				if ($urandom_range(0, 3) != 0)
					sent += add_word({LOW_MARK, 16'($urandom())});
				if (first && ext_mode)
					k = 34;
				else if ($urandom_range(0, 9) == 0)
					k = $urandom_range(30, 36);
				else
					k = $urandom_range(0, 6);
				first = 1'b0;
				for (int i = 0; i < k; i++) begin
					sent += add_word(random_hit());
					if ($urandom_range(0, 15) == 0)
						sent += add_word(noise_word());
				end
				if ($urandom_range(0, 15) != 0)
					sent += add_word(eoe_word());
			end else begin
				sent += add_word(noise_word());
			end
		end
	endtask

	initial begin : sequencer
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 16;
		recv_stall_pct = 70;

		// counter stamping, largest module number
		write_reg(CFG_MODE, 8'd0);
		write_reg(CFG_MODULE, 8'hFF);
		void'(add_word({HDR_MARK, 24'h000000}));
		void'(add_word(hit_word(5'd0, 1'b0, 14'h0000)));
		void'(add_word({HIT_MARK, 1'b1, 5'd31, 1'b1, 1'b0, 14'h3FFF}));
		void'(add_word(hit_word(5'd5, 1'b1, 14'h1234)));
		void'(add_word({LOW_MARK, 16'hFFFF}));
		void'(add_word(32'h0));
		void'(add_word({WT_UNUSED, 30'h3FFFFFFF}));
		void'(add_word({WT_HEADER, 6'h3F, 24'hFFFFFF}));
		void'(add_word(32'h0000_0001));
		void'(add_word({WT_EOE, 30'h0}));
		void'(add_word(hit_word(5'd17, 1'b0, 14'h2AAA)));
		void'(add_word(32'hFFFF_FFFF));
		settle();

		// extended stamping, smallest module number
		write_reg(CFG_MODE, 8'd1);
		write_reg(CFG_MODULE, 8'h00);
		void'(add_word(good_header()));
		void'(add_word({LOW_MARK, 16'hA5C3}));
		void'(add_word(hit_word(5'd31, 1'b1, 14'h3FFF)));
		void'(add_word(hit_word(5'd0, 1'b0, 14'h0000)));
		void'(add_word({WT_EOE, 30'h3FFFFFFF}));
		void'(add_word(good_header()));
		void'(add_word(hit_word(5'd7, 1'b0, 14'h0155)));
		void'(add_word(eoe_word()));
		// pending hits thrown away by a new header
		void'(add_word(good_header()));
		void'(add_word(random_hit()));
		void'(add_word({LOW_MARK, 16'h0001}));
		void'(add_word(good_header()));
		void'(add_word(eoe_word()));
		// left pending across the switch back to counter stamping
		void'(add_word(good_header()));
		void'(add_word(random_hit()));
		settle();

		for (int r = 0; r < 3; r++) begin
			send_idle_pct = (r == 0) ? 16 : (r == 1) ? 70 : 0;
			recv_stall_pct = (r == 0) ? 70 : (r == 1) ? 16 : 0;
			for (int h = 0; h < 2; h++) begin
				write_reg(CFG_MODE, 8'((r + h) % 2));
				write_reg(CFG_MODULE, 8'($urandom_range(0, 255)));
				if (r == 0 && h == 0)
					void'(add_word(eoe_word()));
				queue_traffic(50);
				settle();
			end
		end

		$display("covered %0d accepted words and %0d checked results", words_taken,
			results_checked);
		$display("across %0d register writes in both stamping modes", reg_writes);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/aewd_pkg.sv
rtl/core/aewd_ctrl.sv
rtl/core/aewd_dp.sv
rtl/core/adc_event_word_decoder.sv
tb/sv/testbench.sv
